// ----- src/grid_density_histogram_dedup_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the track density grid
// Concurrent assertion wrappers, clocked on clk and disabled while rst_n is
// low. Defining ASSERT_OFF turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef GRID_DENSITY_HISTOGRAM_DEDUP_TOP_DEFINES_SVH
`define GRID_DENSITY_HISTOGRAM_DEDUP_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define GDH_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define GDH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define GDH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GDH_ASSERT_ALWAYS(lbl, cond, msg)
`define GDH_ASSERT_IMPL(lbl, ante, cons, msg)
`define GDH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- src/gdh_pkg.sv -----
// ----------------------------------------------------------------------------
// gdh_pkg
// Types, codes and default sizes shared by the track density grid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdh_pkg;

    // Default sizes of the grid and of the pending cell list.
    localparam int DEF_MAX_LAT         = 128;
    localparam int DEF_MAX_LON         = 256;
    localparam int DEF_MAX_TRACK_CELLS = 256;

    // Field widths of the items.
    localparam int OPCODE_W   = 2;
    localparam int TRACK_ID_W = 24;
    localparam int LAT_W      = 7;
    localparam int LON_W      = 8;
    localparam int COUNT_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    // Configuration port.
    localparam int LAT_COUNT_W  = 8;
    localparam int LON_COUNT_W  = 9;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 9;

    localparam logic [LAT_COUNT_W-1:0] LAT_COUNT_RESET = 8'd128;
    localparam logic [LON_COUNT_W-1:0] LON_COUNT_RESET = 9'd256;

    localparam logic [CFG_INDEX_W-1:0] REG_LAT_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LON_COUNT = 2'd1;

    localparam logic [OPCODE_W-1:0] OP_NODE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_EOF  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LAT_OOR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LON_OOR = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLOSE,
        ST_NODE,
        ST_READ,
        ST_RESP
    } state_t;

endpackage

// ----- src/gdh_ram.sv -----
// ----------------------------------------------------------------------------
// gdh_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- src/grid_density_histogram_dedup_top.sv -----
// ----------------------------------------------------------------------------
// grid_density_histogram_dedup_top
// Track density grid: counts every distinct cell of each track once.
// ----------------------------------------------------------------------------
// After reset the block sweeps the grid memory to zero, one cell per cycle;
// no item is accepted during that pass, while configuration writes are. One
// item is taken at a time. A read, or a node that closes no track, first
// reads the grid word (count and visited mark) and then uses it and, for a
// node, writes the mark back and appends the cell to the pending list. An
// item that is out of range, an end of file with no open track, and an
// unused opcode are answered without a memory read. Closing a track walks
// the pending list through a three-stage read-read-write pipeline over the
// two memories; a node that closes the previous track then records its own
// cell. Results pass through an output register with one holding register
// behind it, so a stalled master side blocks the input only once both of
// them are full.
`timescale 1ns / 1ps
`include "grid_density_histogram_dedup_top_defines.svh"

module grid_density_histogram_dedup_top #(
    parameter int MAX_LAT         = gdh_pkg::DEF_MAX_LAT,
    parameter int MAX_LON         = gdh_pkg::DEF_MAX_LON,
    parameter int MAX_TRACK_CELLS = gdh_pkg::DEF_MAX_TRACK_CELLS
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // Input items.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [23:0] track_id, [30:24] lat_index, [38:31] lon_index, [39] zero
    input  logic [gdh_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] opcode
    input  logic [gdh_pkg::OPCODE_W-1:0]       s_axis_tuser,

    // Result items.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] cell_count
    output logic [gdh_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [1:0] status
    output logic [gdh_pkg::STATUS_W-1:0]       m_axis_tuser,

    // Configuration writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gdh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gdh_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import gdh_pkg::*;

    localparam int GRID_CELLS = MAX_LAT * MAX_LON;
    localparam int GADDR_W    = $clog2(GRID_CELLS);
    localparam int GRID_W     = COUNT_W + 1;
    localparam int PIDX_W     = $clog2(MAX_TRACK_CELLS);
    localparam int TOTAL_W    = $clog2(MAX_TRACK_CELLS + 1);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(MAX_TRACK_CELLS);

    state_t               state_reg, state_next;
    logic [GADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [LAT_COUNT_W-1:0] lat_count_reg, lat_count_next;
    logic [LON_COUNT_W-1:0] lon_count_reg, lon_count_next;
    logic                 track_open_reg, track_open_next;
    logic [TRACK_ID_W-1:0] open_id_reg, open_id_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [TOTAL_W-1:0]   idx_reg, idx_next;
    logic                 v1_reg, v1_next;
    logic                 v2_reg, v2_next;
    logic [GADDR_W-1:0]   wa_reg, wa_next;
    logic [GADDR_W-1:0]   node_addr_reg, node_addr_next;
    logic [TRACK_ID_W-1:0] item_tid_reg, item_tid_next;
    logic                 close_node_reg, close_node_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [COUNT_W-1:0]   res_count_reg, res_count_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;

    // Memory ports. The grid word holds the count and, above it, the mark.
    logic                 grid_wr_en;
    logic [GADDR_W-1:0]   grid_wr_addr;
    logic [GRID_W-1:0]    grid_wr_data;
    logic [GADDR_W-1:0]   grid_rd_addr;
    logic [GRID_W-1:0]    grid_rd_data;
    logic                 pend_wr_en;
    logic [PIDX_W-1:0]    pend_wr_addr;
    logic [GADDR_W-1:0]   pend_wr_data;
    logic [PIDX_W-1:0]    pend_rd_addr;
    logic [GADDR_W-1:0]   pend_rd_data;

    // Input fields.
    logic [TRACK_ID_W-1:0] in_tid;
    logic [LAT_W-1:0]     in_lat;
    logic [LON_W-1:0]     in_lon;
    logic [GADDR_W-1:0]   in_addr;
    logic [STATUS_W-1:0]  in_status;
    logic                 in_acc;
    logic                 can_out;
    logic                 fin;
    logic [COUNT_W-1:0]   fin_count;
    logic [STATUS_W-1:0]  fin_status;
    logic                 close_done;
    logic [COUNT_W-1:0]   close_count;
    logic                 cell_append;

    assign in_tid = s_axis_tdata[TRACK_ID_W-1:0];
    assign in_lat = s_axis_tdata[TRACK_ID_W+LAT_W-1:TRACK_ID_W];
    assign in_lon = s_axis_tdata[TRACK_ID_W+LAT_W+LON_W-1:TRACK_ID_W+LAT_W];

    assign in_addr = GADDR_W'(GADDR_W'(in_lat) * GADDR_W'(MAX_LON)) + GADDR_W'(in_lon);

    // Row is checked before column.
    always_comb
    begin
        if ((32'(in_lat) >= 32'(lat_count_reg)) || (32'(in_lat) >= 32'(MAX_LAT)))
        begin
            in_status = STATUS_LAT_OOR;
        end
        else if ((32'(in_lon) >= 32'(lon_count_reg)) || (32'(in_lon) >= 32'(MAX_LON)))
        begin
            in_status = STATUS_LON_OOR;
        end
        else
        begin
            in_status = STATUS_OK;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign can_out       = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_count_reg;
    assign m_axis_tuser  = out_status_reg;

    assign close_done  = (idx_reg == total_reg) && !v1_reg && !v2_reg;
    assign close_count = (grid_rd_data[COUNT_W-1:0] == {COUNT_W{1'b1}}) ?
                         grid_rd_data[COUNT_W-1:0] :
                         grid_rd_data[COUNT_W-1:0] + 1'b1;

    // An unmarked cell of a node goes on the list while there is room for it.
    assign cell_append = (state_reg == ST_NODE) && !grid_rd_data[COUNT_W] &&
                         (total_reg < TOTAL_MAX);

    gdh_ram #(
        .WIDTH (GRID_W),
        .DEPTH (GRID_CELLS)
    ) u_grid_ram (
        .clk     (clk),
        .wr_en   (grid_wr_en),
        .wr_addr (grid_wr_addr),
        .wr_data (grid_wr_data),
        .rd_addr (grid_rd_addr),
        .rd_data (grid_rd_data)
    );

    gdh_ram #(
        .WIDTH (GADDR_W),
        .DEPTH (MAX_TRACK_CELLS)
    ) u_pend_ram (
        .clk     (clk),
        .wr_en   (pend_wr_en),
        .wr_addr (pend_wr_addr),
        .wr_data (pend_wr_data),
        .rd_addr (pend_rd_addr),
        .rd_data (pend_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            lat_count_reg  <= LAT_COUNT_RESET;
            lon_count_reg  <= LON_COUNT_RESET;
            track_open_reg <= 1'b0;
            open_id_reg    <= '0;
            total_reg      <= '0;
            idx_reg        <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            close_node_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            lat_count_reg  <= lat_count_next;
            lon_count_reg  <= lon_count_next;
            track_open_reg <= track_open_next;
            open_id_reg    <= open_id_next;
            total_reg      <= total_next;
            idx_reg        <= idx_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            close_node_reg <= close_node_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg         <= wa_next;
        node_addr_reg  <= node_addr_next;
        item_tid_reg   <= item_tid_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        lat_count_next  = lat_count_reg;
        lon_count_next  = lon_count_reg;
        track_open_next = track_open_reg;
        open_id_next    = open_id_reg;
        total_next      = total_reg;
        idx_next        = idx_reg;
        v1_next         = v1_reg;
        v2_next         = v2_reg;
        wa_next         = wa_reg;
        node_addr_next  = node_addr_reg;
        item_tid_next   = item_tid_reg;
        close_node_next = close_node_reg;
        out_valid_next  = out_valid_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;

        grid_wr_en   = 1'b0;
        grid_wr_addr = node_addr_reg;
        grid_wr_data = '0;
        grid_rd_addr = node_addr_reg;
        pend_wr_en   = 1'b0;
        pend_wr_addr = total_reg[PIDX_W-1:0];
        pend_wr_data = node_addr_reg;
        pend_rd_addr = idx_reg[PIDX_W-1:0];

        fin        = 1'b0;
        fin_count  = '0;
        fin_status = STATUS_OK;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LAT_COUNT: lat_count_next = cfg_data[LAT_COUNT_W-1:0];
                REG_LON_COUNT: lon_count_next = cfg_data[LON_COUNT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                grid_wr_en   = 1'b1;
                grid_wr_addr = clr_addr_reg;
                grid_wr_data = '0;
                if (clr_addr_reg == GADDR_W'(GRID_CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_acc)
                begin
                    node_addr_next = in_addr;
                    item_tid_next  = in_tid;
                    case (s_axis_tuser)
                        OP_NODE:
                        begin
                            if (in_status != STATUS_OK)
                            begin
                                fin        = 1'b1;
                                fin_status = in_status;
                            end
                            else if (track_open_reg && (in_tid != open_id_reg))
                            begin
                                close_node_next = 1'b1;
                                idx_next        = '0;
                                state_next      = ST_CLOSE;
                            end
                            else
                            begin
                                track_open_next = 1'b1;
                                open_id_next    = in_tid;
                                grid_rd_addr    = in_addr;
                                state_next      = ST_NODE;
                            end
                        end

                        OP_EOF:
                        begin
                            if (track_open_reg)
                            begin
                                close_node_next = 1'b0;
                                idx_next        = '0;
                                state_next      = ST_CLOSE;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end

                        OP_READ:
                        begin
                            if (in_status != STATUS_OK)
                            begin
                                fin        = 1'b1;
                                fin_status = in_status;
                            end
                            else
                            begin
                                grid_rd_addr = in_addr;
                                state_next   = ST_READ;
                            end
                        end

                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            ST_CLOSE:
            begin
                // Stage 0: fetch the next pending cell address.
                if (idx_reg < total_reg)
                begin
                    pend_rd_addr = idx_reg[PIDX_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                    v1_next      = 1'b1;
                end
                else
                begin
                    v1_next = 1'b0;
                end

                // Stage 1: fetch that cell's grid word.
                if (v1_reg)
                begin
                    grid_rd_addr = pend_rd_data;
                    wa_next      = pend_rd_data;
                    v2_next      = 1'b1;
                end
                else
                begin
                    v2_next = 1'b0;
                end

                // Stage 2: bump the count and clear the mark. Pending cells are
                // distinct, so no two stages ever touch the same grid word.
                if (v2_reg)
                begin
                    grid_wr_en   = 1'b1;
                    grid_wr_addr = wa_reg;
                    grid_wr_data = {1'b0, close_count};
                end

                if (close_done)
                begin
                    total_next      = '0;
                    track_open_next = 1'b0;
                    if (close_node_reg)
                    begin
                        track_open_next = 1'b1;
                        open_id_next    = item_tid_reg;
                        grid_rd_addr    = node_addr_reg;
                        state_next      = ST_NODE;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end

            ST_NODE:
            begin
                fin = 1'b1;
                if (cell_append)
                begin
                    grid_wr_en   = 1'b1;
                    grid_wr_addr = node_addr_reg;
                    grid_wr_data = {1'b1, grid_rd_data[COUNT_W-1:0]};
                    pend_wr_en   = 1'b1;
                    pend_wr_addr = total_reg[PIDX_W-1:0];
                    pend_wr_data = node_addr_reg;
                    total_next   = total_reg + 1'b1;
                end
                else if (!grid_rd_data[COUNT_W])
                begin
                    fin_status = STATUS_FULL;
                end
            end

            ST_READ:
            begin
                fin       = 1'b1;
                fin_count = grid_rd_data[COUNT_W-1:0];
            end

            ST_RESP:
            begin
                if (can_out)
                begin
                    out_valid_next  = 1'b1;
                    out_count_next  = res_count_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is
        // free, and otherwise waits in the holding register.
        if (fin)
        begin
            if (can_out)
            begin
                out_valid_next  = 1'b1;
                out_count_next  = fin_count;
                out_status_next = fin_status;
                state_next      = ST_IDLE;
            end
            else
            begin
                res_count_next  = fin_count;
                res_status_next = fin_status;
                state_next      = ST_RESP;
            end
        end
    end

    `GDH_ASSERT_ALWAYS(a_total_bound, total_reg <= TOTAL_MAX, "pending list overrun")
    `GDH_ASSERT_NEXT(a_mark_appends, cell_append, total_reg == $past(total_reg) + 1'b1, "no append")
    `GDH_ASSERT_IMPL(a_idle_drained, state_reg == ST_IDLE, !v1_reg && !v2_reg, "close busy")
    `GDH_ASSERT_IMPL(a_resp_blocked, state_reg == ST_RESP, out_valid_reg, "held with free output")
    `GDH_ASSERT_NEXT(a_close_empties, state_reg == ST_CLOSE && close_done, total_reg == '0, "cells left")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the track density grid with per-track dedup.
// Items are driven on the input stream from a backlog, and every result is
// checked against a cycle-free prediction of the grid, the visited marks, the
// pending cell list and the open track. The run walks through several grid
// limit settings, with bursty input, random output stalls and one long
// output hold-off per selected phase.
// ----------------------------------------------------------------------------

module tb;
    import gdh_pkg::*;

    localparam int                  GRID_CELLS       = DEF_MAX_LAT * DEF_MAX_LON;
    localparam logic [OPCODE_W-1:0] OP_UNUSED        = 2'd3;
    localparam logic [COUNT_W-1:0]  COUNT_MAX        = 32'hFFFF_FFFF;
    localparam int                  PHASE_SETTLE     = 8;
    localparam int                  END_SETTLE       = 300;
    localparam int                  LONG_HOLD_CYCLES = 400;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [TRACK_ID_W-1:0] track_id;
        logic [LAT_W-1:0]      lat;
        logic [LON_W-1:0]      lon;
    } grid_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  cell_count;
        logic [STATUS_W-1:0] status;
    } grid_result_t;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [OPCODE_W-1:0]    s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    // Predicted block state.
    bit [COUNT_W-1:0]       grid_counts [GRID_CELLS];
    bit                     cell_marked [GRID_CELLS];
    int                     track_cells [$];
    bit [TRACK_ID_W-1:0]    open_id;
    bit                     open_flag;
    bit [LAT_COUNT_W-1:0]   lat_limit = LAT_COUNT_RESET;
    bit [LON_COUNT_W-1:0]   lon_limit = LON_COUNT_RESET;

    grid_item_t             item_backlog [$];
    grid_result_t           owed_results [$];
    int                     error_count;
    int                     queued_total;
    logic                   in_fire = 1'b0;
    int                     gap_left;
    int                     burst_left;
    int                     hold_left;
    int                     mode_left;
    int                     ready_mode;
    bit                     long_hold_req;
    bit [TRACK_ID_W-1:0]    last_track;
    int                     hot_lat;
    int                     hot_lon;

    grid_density_histogram_dedup_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [STATUS_W-1:0] range_status(logic [LAT_W-1:0] lat,
                                                         logic [LON_W-1:0] lon);
        // The row is checked before the column.
        if (int'(lat) >= int'(lat_limit) || int'(lat) >= DEF_MAX_LAT)
            return STATUS_LAT_OOR;
        if (int'(lon) >= int'(lon_limit) || int'(lon) >= DEF_MAX_LON)
            return STATUS_LON_OOR;
        return STATUS_OK;
    endfunction

    function automatic void close_open_track();
        foreach (track_cells[i])
        begin
            if (grid_counts[track_cells[i]] != COUNT_MAX)
                grid_counts[track_cells[i]]++;
            cell_marked[track_cells[i]] = 1'b0;
        end
        track_cells.delete();
        open_flag = 1'b0;
    endfunction

    function automatic void apply_grid_item(grid_item_t it);
        grid_result_t res;
        int           addr;
        res  = '0;
        addr = int'(it.lat) * DEF_MAX_LON + int'(it.lon);
        case (it.opcode)
            OP_NODE:
            begin
                res.status = range_status(it.lat, it.lon);
                // An out-of-range node leaves the open track alone.
                if (res.status == STATUS_OK)
                begin
                    if (!open_flag || it.track_id != open_id)
                    begin
                        if (open_flag)
                            close_open_track();
                        open_id   = it.track_id;
                        open_flag = 1'b1;
                    end
                    if (!cell_marked[addr])
                    begin
                        if (track_cells.size() >= DEF_MAX_TRACK_CELLS)
                            res.status = STATUS_FULL;
                        else
                        begin
                            cell_marked[addr] = 1'b1;
                            track_cells.insert(track_cells.size(), addr);
                        end
                    end
                end
            end
            OP_EOF:
            begin
                if (open_flag)
                    close_open_track();
            end
            OP_READ:
            begin
                res.status = range_status(it.lat, it.lon);
                if (res.status == STATUS_OK)
                    res.cell_count = grid_counts[addr];
            end
            default:
            begin
            end
        endcase
        owed_results.insert(owed_results.size(), res);
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        error_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: checks results and predicts accepted items.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_streams
        grid_result_t want;
        grid_item_t   seen;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (owed_results.size() == 0)
            begin
                error_count++;
                $display("%0t ns: expected no result, actual count %0d status %0d",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = owed_results.pop_front();
                if (m_axis_tdata !== want.cell_count)
                    note_mismatch("cell_count", want.cell_count, m_axis_tdata);
                if (m_axis_tuser !== want.status)
                    note_mismatch("status", want.status, m_axis_tuser);
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            seen.opcode   = s_axis_tuser;
            seen.track_id = s_axis_tdata[23:0];
            seen.lat      = s_axis_tdata[30:24];
            seen.lon      = s_axis_tdata[38:31];
            apply_grid_item(seen);
        end
        in_fire <= rst_n && s_axis_tvalid && s_axis_tready;
    end

    // ------------------------------------------------------------------
    // Driver: offers backlog items in bursts with random gaps.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_items
        bit         offer;
        grid_item_t nxt;
        offer = s_axis_tvalid && !in_fire;
        if (rst_n && !offer)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (item_backlog.size() > 0)
            begin
                nxt = item_backlog.pop_front();
                s_axis_tuser <= nxt.opcode;
                s_axis_tdata <= {1'b0, nxt.lon, nxt.lat, nxt.track_id};
                offer = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                            : $urandom_range(0, 2);
                end
            end
        end
        s_axis_tvalid <= offer;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall modes, plus a long hold-off on request.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : accept_results
        bit rdy;
        if (hold_left > 0)
        begin
            hold_left--;
            rdy = 1'b0;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD_CYCLES;
            rdy           = 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 128);
            end
            else
                mode_left--;
            case (ready_mode)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 1);
                2:       rdy = ($urandom_range(0, 3) == 0);
                default: rdy = ($urandom_range(0, 7) != 0);
            endcase
        end
        m_axis_tready <= rdy;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_item(logic [OPCODE_W-1:0] op, logic [TRACK_ID_W-1:0] tid,
                                       int lat, int lon);
        grid_item_t it;
        it.opcode   = op;
        it.track_id = tid;
        it.lat      = LAT_W'(lat);
        it.lon      = LON_W'(lon);
        item_backlog.insert(item_backlog.size(), it);
        queued_total++;
    endfunction

    // Mostly near the hot spot so that cells repeat and reads find counts.
    function automatic int pick_coord(int hot, int limit, int max_size, int field_top);
        int span;
        span = (limit < max_size) ? limit : max_size;
        if (span == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, field_top);
        return (hot + $urandom_range(0, 5)) % span;
    endfunction

    function automatic int pick_lat();
        return pick_coord(hot_lat, int'(lat_limit), DEF_MAX_LAT, 2**LAT_W - 1);
    endfunction

    function automatic int pick_lon();
        return pick_coord(hot_lon, int'(lon_limit), DEF_MAX_LON, 2**LON_W - 1);
    endfunction

    function automatic void queue_random_phase(int n_items);
        int                  stop_at;
        int                  kind;
        int                  len;
        bit [TRACK_ID_W-1:0] tid;
        stop_at = queued_total + n_items;
        hot_lat = $urandom_range(0, DEF_MAX_LAT - 1);
        hot_lon = $urandom_range(0, DEF_MAX_LON - 1);
        while (queued_total < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                // A track: sometimes it continues the previous id.
                tid        = ($urandom_range(0, 4) == 0) ? last_track : TRACK_ID_W'($urandom);
                last_track = tid;
                len        = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 12);
                if ($urandom_range(0, 9) == 0)
                begin
                    hot_lat = $urandom_range(0, DEF_MAX_LAT - 1);
                    hot_lon = $urandom_range(0, DEF_MAX_LON - 1);
                end
                repeat (len)
                    queue_item(OP_NODE, tid, pick_lat(), pick_lon());
                if ($urandom_range(0, 1) == 1)
                    queue_item(OP_EOF, TRACK_ID_W'($urandom), $urandom, $urandom);
            end
            else if (kind < 85)
            begin
                repeat ($urandom_range(1, 4))
                    queue_item(OP_READ, TRACK_ID_W'($urandom), pick_lat(), pick_lon());
            end
            else if (kind < 92)
                queue_item(OP_EOF, TRACK_ID_W'($urandom), $urandom, $urandom);
            else
                queue_item(OPCODE_W'($urandom_range(0, 3)), TRACK_ID_W'($urandom),
                           $urandom_range(0, 2**LAT_W - 1), $urandom_range(0, 2**LON_W - 1));
        end
    endfunction

    task automatic write_grid_limit(logic [CFG_INDEX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == REG_LAT_COUNT)
            lat_limit = LAT_COUNT_W'(value);
        else
            lon_limit = LON_COUNT_W'(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(int lat, int lon);
        write_grid_limit(REG_LAT_COUNT, lat);
        write_grid_limit(REG_LON_COUNT, lon);
    endtask

    task automatic wait_idle(int settle);
        while (item_backlog.size() != 0 || s_axis_tvalid || owed_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        bit [TRACK_ID_W-1:0] long_tid;
        int                  base;
        int                  k;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Full grid. Limit writes are taken during the clearing sweep.
        set_limits(DEF_MAX_LAT, DEF_MAX_LON);
        queue_item(OP_READ, 24'h000000, 0, 0);
        queue_item(OP_EOF, 24'h000000, 0, 0);
        queue_item(OP_UNUSED, 24'hFFFFFF, 127, 255);
        queue_item(OP_NODE, 24'h000000, 0, 0);
        queue_item(OP_NODE, 24'h000000, 0, 0);
        queue_item(OP_NODE, 24'h000000, 127, 255);
        // A new id closes the previous track before the node is recorded.
        queue_item(OP_NODE, 24'hFFFFFF, 0, 0);
        queue_item(OP_READ, 24'hFFFFFF, 0, 0);
        queue_item(OP_READ, 24'h000000, 127, 255);
        queue_item(OP_NODE, 24'hFFFFFF, 127, 255);
        queue_item(OP_EOF, 24'hFFFFFF, 127, 255);
        queue_item(OP_READ, 24'h000000, 127, 255);
        queue_item(OP_NODE, 24'h555555, 8'h55, 8'hAA);
        queue_item(OP_NODE, 24'hAAAAAA, 8'h2A, 8'h55);
        queue_item(OP_READ, 24'h555555, 8'h55, 8'hAA);
        queue_random_phase(220);
        wait_idle(PHASE_SETTLE);

        // Single cell: almost everything falls out of range.
        set_limits(1, 1);
        queue_item(OP_NODE, 24'h000001, 0, 0);
        queue_item(OP_NODE, 24'h000002, 1, 0);
        queue_item(OP_NODE, 24'h000002, 0, 1);
        queue_item(OP_NODE, 24'h000002, 1, 1);
        queue_item(OP_READ, 24'h000000, 1, 0);
        queue_item(OP_READ, 24'h000000, 0, 1);
        queue_item(OP_EOF, 24'h000000, 0, 0);
        queue_item(OP_READ, 24'h000000, 0, 0);
        queue_random_phase(80);
        wait_idle(PHASE_SETTLE);

        set_limits($urandom_range(2, DEF_MAX_LAT - 1), $urandom_range(2, DEF_MAX_LON - 1));
        long_hold_req = 1'b1;
        queue_random_phase(220);
        wait_idle(PHASE_SETTLE);

        set_limits(DEF_MAX_LAT, 1);
        queue_random_phase(100);
        wait_idle(PHASE_SETTLE);

        set_limits(1, DEF_MAX_LON);
        queue_random_phase(100);
        wait_idle(PHASE_SETTLE);

        // One track with more distinct cells than the pending list holds.
        set_limits(DEF_MAX_LAT, DEF_MAX_LON);
        long_hold_req = 1'b1;
        long_tid      = TRACK_ID_W'($urandom);
        base          = $urandom_range(0, GRID_CELLS - DEF_MAX_TRACK_CELLS - 50);
        for (k = 0; k < DEF_MAX_TRACK_CELLS + 40; k++)
            queue_item(OP_NODE, long_tid, (base + k) / DEF_MAX_LON, (base + k) % DEF_MAX_LON);
        queue_item(OP_NODE, long_tid, base / DEF_MAX_LON, base % DEF_MAX_LON);
        queue_item(OP_EOF, long_tid, 0, 0);
        k = base + DEF_MAX_TRACK_CELLS - 1;
        queue_item(OP_READ, long_tid, k / DEF_MAX_LON, k % DEF_MAX_LON);
        k = base + DEF_MAX_TRACK_CELLS;
        queue_item(OP_READ, long_tid, k / DEF_MAX_LON, k % DEF_MAX_LON);
        queue_random_phase(150);
        wait_idle(END_SETTLE);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #8000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/gdh_pkg.sv
src/gdh_ram.sv
src/grid_density_histogram_dedup_top.sv
tb/sv/tb.sv
